### rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the RGB to HSV converter
// Widths, hue angle constants and the beat carried down the divider chain.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int COMPONENT_BITS = 8;
   localparam int HUE_FRAC_BITS  = 6;
   localparam int HUE_BITS       = 9 + HUE_FRAC_BITS;

   localparam int DEG60_INT = 60 << HUE_FRAC_BITS;
   localparam int FULL_INT  = (1 << COMPONENT_BITS) - 1;

   // quotient bits: hue term reaches DEG60, saturation reaches FULL
   localparam int QUO_BITS = ($clog2(DEG60_INT + 1) > COMPONENT_BITS) ?
                             $clog2(DEG60_INT + 1) : COMPONENT_BITS;
   // partial remainder and shifted divisor width
   localparam int REM_BITS = QUO_BITS + COMPONENT_BITS;

   localparam logic [HUE_BITS-1:0] DEG120 = HUE_BITS'(120 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] DEG240 = HUE_BITS'(240 << HUE_FRAC_BITS);
   localparam logic [HUE_BITS-1:0] DEG360 = HUE_BITS'(360 << HUE_FRAC_BITS);

   typedef logic [COMPONENT_BITS-1:0] comp_type;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // pixel data that rides along with the division
   typedef struct packed {
      sector_type sector;
      logic       neg;      // negative hue term
      logic       grey;     // delta is zero
      logic       dark;     // max is zero
      comp_type   brightness;
   } side_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem_h;
      logic [REM_BITS-1:0] div_h;
      logic [QUO_BITS-1:0] quo_h;
      logic [REM_BITS-1:0] rem_s;
      logic [REM_BITS-1:0] div_s;
      logic [QUO_BITS-1:0] quo_s;
      side_type            side;
   } cell_beat_type;

endpackage

### rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front: max/min search and divider setup
// Finds max, min and the hue sector, forms both dividends and the divisors
// aligned to the top quotient bit, and registers them as the first beat.
// ----------------------------------------------------------------------------
module hsv_front
   import hsv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  comp_type      red,
   input  comp_type      green,
   input  comp_type      blue,
   output logic          up_stall,
   output logic          dn_valid,
   output cell_beat_type dn_beat,
   input  logic          dn_stall
);

   logic          valid_ff, valid_in;
   cell_beat_type beat_ff, beat_in;
   logic          load;

   comp_type   mx, mn, delta, pos, neg_c, diff;
   sector_type sector;

   always_comb begin
      // ties go red, then green, then blue
      if (red >= green && red >= blue) begin
         sector = SECT_RED;
         mx     = red;
         pos    = green;
         neg_c  = blue;
      end else if (green >= blue) begin
         sector = SECT_GREEN;
         mx     = green;
         pos    = blue;
         neg_c  = red;
      end else begin
         sector = SECT_BLUE;
         mx     = blue;
         pos    = red;
         neg_c  = green;
      end
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      diff  = (pos >= neg_c) ? (pos - neg_c) : (neg_c - pos);
   end

   always_comb begin
      beat_in.rem_h = REM_BITS'(diff) * REM_BITS'(DEG60_INT);
      beat_in.div_h = REM_BITS'(delta) << (QUO_BITS - 1);
      beat_in.quo_h = '0;
      beat_in.rem_s = REM_BITS'(delta) * REM_BITS'(FULL_INT);
      beat_in.div_s = REM_BITS'(mx) << (QUO_BITS - 1);
      beat_in.quo_s = '0;
      beat_in.side.sector     = sector;
      beat_in.side.neg        = (pos < neg_c);
      beat_in.side.grey       = (delta == '0);
      beat_in.side.dark       = (mx == '0);
      beat_in.side.brightness = mx;
   end

   assign load     = !valid_ff || !dn_stall;
   assign up_stall = !load;
   assign valid_in = load ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

### rtl/hsv_div_cell.sv
// ----------------------------------------------------------------------------
// hsv_div_cell: one restoring division step for hue and saturation
// Resolves one quotient bit of each division, halves the divisors and hands
// the beat to the next cell.
// ----------------------------------------------------------------------------
module hsv_div_cell
   import hsv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   input  cell_beat_type up_beat,
   output logic          up_stall,
   output logic          dn_valid,
   output cell_beat_type dn_beat,
   input  logic          dn_stall
);

   logic          valid_ff, valid_in;
   cell_beat_type beat_ff, beat_in;
   logic          load;
   logic          ge_h, ge_s;

   always_comb begin
      ge_h = (up_beat.rem_h >= up_beat.div_h);
      ge_s = (up_beat.rem_s >= up_beat.div_s);
      beat_in       = up_beat;
      beat_in.rem_h = ge_h ? (up_beat.rem_h - up_beat.div_h) : up_beat.rem_h;
      beat_in.rem_s = ge_s ? (up_beat.rem_s - up_beat.div_s) : up_beat.rem_s;
      beat_in.div_h = up_beat.div_h >> 1;
      beat_in.div_s = up_beat.div_s >> 1;
      beat_in.quo_h = {up_beat.quo_h[QUO_BITS-2:0], ge_h};
      beat_in.quo_s = {up_beat.quo_s[QUO_BITS-2:0], ge_s};
   end

   assign load     = !valid_ff || !dn_stall;
   assign up_stall = !load;
   assign valid_in = load ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_beat  = beat_ff;

endmodule

### rtl/hsv_back.sv
// ----------------------------------------------------------------------------
// hsv_back: hue assembly and result register
// Adds the sector offset to the hue quotient, handles grey and black pixels
// and holds the result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module hsv_back
   import hsv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                up_valid,
   input  cell_beat_type       up_beat,
   output logic                up_stall,
   output logic                rsp_valid,
   output logic [HUE_BITS-1:0] rsp_hue,
   output comp_type            rsp_saturation,
   output comp_type            rsp_brightness,
   input  logic                rsp_stall
);

   logic                valid_ff, valid_in;
   logic [HUE_BITS-1:0] hue_ff, hue_in;
   comp_type            sat_ff, sat_in;
   comp_type            bright_ff;
   logic                load;
   logic [HUE_BITS-1:0] offset, quo, sum;

   always_comb begin
      unique case (up_beat.side.sector)
         SECT_RED:   offset = '0;
         SECT_GREEN: offset = DEG120;
         SECT_BLUE:  offset = DEG240;
         default:    offset = '0;
      endcase
      quo = HUE_BITS'(up_beat.quo_h);
      // negative term: only the red sector can go below zero and wrap
      if (up_beat.side.neg) begin
         sum = (offset >= quo) ? (offset - quo) : (offset + DEG360 - quo);
      end else begin
         sum = offset + quo;
      end
      // a full circle folds back to zero
      if (sum >= DEG360) begin
         sum = sum - DEG360;
      end
      hue_in = up_beat.side.grey ? '0 : sum;
      sat_in = up_beat.side.dark ? '0 : up_beat.quo_s[COMPONENT_BITS-1:0];
   end

   assign load     = !valid_ff || !rsp_stall;
   assign up_stall = !load;
   assign valid_in = load ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= up_beat.side.brightness;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

endmodule

### rtl/rgb_to_hsv_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_unit: pipelined RGB to HSV pixel converter
//
// Request channel (req_*): one RGB pixel per beat, 8 bits per component.
// Response channel (rsp_*): hue in 1/64 degree, saturation and brightness.
// Both use valid/stall; a beat moves when valid is high and stall is low.
//
// The pixel goes through a setup stage, a chain of 12 division cells (one
// quotient bit of hue and of saturation per cell) and a result register:
// 14 register stages, and one pixel is accepted every cycle unless
// req_stall is high.
// Each stage holds its beat while the next one is full and stalled, so
// empty stages keep filling while a result waits; req_stall rises only
// when the whole chain is full and rsp_stall is high.
// Reset clears every stage valid; nothing else needs clearing and the
// block accepts a pixel in the first cycle after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_unit
   import hsv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  comp_type            req_red,
   input  comp_type            req_green,
   input  comp_type            req_blue,
   output logic                req_stall,
   output logic                rsp_valid,
   output logic [HUE_BITS-1:0] rsp_hue,
   output comp_type            rsp_saturation,
   output comp_type            rsp_brightness,
   input  logic                rsp_stall
);

   logic          chain_valid [0:QUO_BITS];
   logic          chain_stall [0:QUO_BITS];
   cell_beat_type chain_beat  [0:QUO_BITS];

   hsv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .up_stall (req_stall),
      .dn_valid (chain_valid[0]),
      .dn_beat  (chain_beat[0]),
      .dn_stall (chain_stall[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      hsv_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_valid[i]),
         .up_beat  (chain_beat[i]),
         .up_stall (chain_stall[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_beat  (chain_beat[i+1]),
         .dn_stall (chain_stall[i+1])
      );
   end

   hsv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .up_valid       (chain_valid[QUO_BITS]),
      .up_beat        (chain_beat[QUO_BITS]),
      .up_stall       (chain_stall[QUO_BITS]),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_stall      (rsp_stall)
   );

endmodule

### tb/tb_rgb_to_hsv_unit.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_unit: self-checking testbench for the RGB to HSV converter
// Pixels go in through the req_ channel with random gaps. Each accepted pixel
// is converted by an integer model in the bench and queued. Every rsp_ beat
// is compared field by field with the oldest queued pixel. The receiver
// stalls at random, and once it holds off long enough to back the pipe up.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_unit;
   import hsv_pkg::*;

   localparam int HUE_UNIT     = 1 << HUE_FRAC_BITS;
   localparam int SIXTY_DEG    = 60 * HUE_UNIT;
   localparam int GREEN_OFFSET = 120 * HUE_UNIT;
   localparam int BLUE_OFFSET  = 240 * HUE_UNIT;
   localparam int FULL_CIRCLE  = 360 * HUE_UNIT;
   localparam int FULL_SCALE   = (1 << COMPONENT_BITS) - 1;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_PIXELS = 1000;

   typedef struct {
      logic [HUE_BITS-1:0] hue;
      comp_type            saturation;
      comp_type            brightness;
   } hsv_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   comp_type            req_red = '0;
   comp_type            req_green = '0;
   comp_type            req_blue = '0;
   logic                req_stall;
   logic                rsp_valid;
   logic [HUE_BITS-1:0] rsp_hue;
   comp_type            rsp_saturation;
   comp_type            rsp_brightness;
   logic                rsp_stall = 1'b0;

   hsv_type pending_hsv[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      send_gaps_on = 1'b0;
   bit      rsp_gaps_on = 1'b0;
   int      stall_left = 0;
   int      hold_off_left = 0;

   rgb_to_hsv_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_stall      (rsp_stall)
   );

   always #1 clock = ~clock;

   function automatic hsv_type rgb_to_hsv_predict(input comp_type r, input comp_type g,
                                                  input comp_type b);
      hsv_type res;
      int      mx;
      int      mn;
      int      delta;
      int      offset;
      int      pos;
      int      neg;
      int      h;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      delta = mx - mn;
      h = 0;
      if (delta != 0) begin
         // ties go to red first, then green
         if (mx == r) begin
            offset = 0;
            pos = g;
            neg = b;
         end else if (mx == g) begin
            offset = GREEN_OFFSET;
            pos = b;
            neg = r;
         end else begin
            offset = BLUE_OFFSET;
            pos = r;
            neg = g;
         end
         if (pos >= neg) h = offset + (SIXTY_DEG * (pos - neg)) / delta;
         else h = offset + FULL_CIRCLE - (SIXTY_DEG * (neg - pos)) / delta;
         while (h >= FULL_CIRCLE) h -= FULL_CIRCLE;
      end
      res.hue = h[HUE_BITS-1:0];
      res.saturation = (mx != 0) ? comp_type'((FULL_SCALE * delta) / mx) : '0;
      res.brightness = comp_type'(mx);
      return res;
   endfunction

   function automatic int rand_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int rand_stall_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_pixel(input comp_type r, input comp_type g, input comp_type b);
      int gap;
      gap = send_gaps_on ? rand_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_hsv.push_back(rgb_to_hsv_predict(r, g, b));
      @(negedge clock);
   endtask

   task automatic test_extremes();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
   endtask

   task automatic test_grey();
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
   endtask

   task automatic test_ties();
      send_pixel(8'd200, 8'd200, 8'd50);   // red and green tie
      send_pixel(8'd50, 8'd200, 8'd200);   // green and blue tie
      send_pixel(8'd200, 8'd50, 8'd200);   // red and blue tie
      send_pixel(8'd255, 8'd255, 8'd254);
   endtask

   // negative hue term in every sector; red sector wraps below 360 degrees
   task automatic test_sector_signs();
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd10, 8'd190);
      send_pixel(8'd255, 8'd0, 8'd254);
      send_pixel(8'd100, 8'd99, 8'd100);
      send_pixel(8'd100, 8'd200, 8'd50);
      send_pixel(8'd50, 8'd100, 8'd200);
      send_pixel(8'd30, 8'd90, 8'd60);
   endtask

   task automatic test_random_pixels();
      comp_type r;
      comp_type g;
      comp_type b;
      int       kind;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         // open with a back-to-back stretch, then random gaps on both sides
         if (i == 0) begin
            send_gaps_on = 1'b0;
            rsp_gaps_on <= 1'b0;
         end else if (i == 200) begin
            send_gaps_on = 1'b1;
            rsp_gaps_on <= 1'b1;
         end
         r = comp_type'($urandom);
         g = comp_type'($urandom);
         b = comp_type'($urandom);
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            g = r;
            b = r;
         end else if (kind < 15) begin
            g = r + comp_type'($urandom_range(0, 2));
            b = r - comp_type'($urandom_range(0, 2));
         end else if (kind < 22) begin
            g = r;
         end else if (kind < 29) begin
            b = g;
         end else if (kind < 35) begin
            b = r;
         end
         send_pixel(r, g, b);
      end
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_back_pressure();
      send_gaps_on = 1'b0;
      hold_off_left <= 250;
      for (int i = 0; i < 40; i++)
         send_pixel(comp_type'($urandom), comp_type'($urandom), comp_type'($urandom));
      send_gaps_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= rand_stall_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      hsv_type exp_hsv;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_hsv.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat: hue %0d sat %0d val %0d",
                        rsp_hue, rsp_saturation, rsp_brightness);
         end else begin
            exp_hsv = pending_hsv.pop_front();
            if (rsp_hue !== exp_hsv.hue || rsp_saturation !== exp_hsv.saturation ||
                rsp_brightness !== exp_hsv.brightness) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/act)",
                           exp_hsv.hue, rsp_hue, exp_hsv.saturation, rsp_saturation,
                           exp_hsv.brightness, rsp_brightness);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** rgb_to_hsv_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_extremes();
      test_grey();
      test_ties();
      test_sector_signs();
      test_random_pixels();
      test_back_pressure();
      req_valid <= 1'b0;
      while (pending_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_hsv.size() == 0)
         $display("** rgb_to_hsv_unit: PASSED **");
      else
         $display("** rgb_to_hsv_unit: FAILED **");
      $finish;
   end

endmodule
